FILE: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// Stable priority queue package
// Entry layout, status codes, operation codes and the cell control bundle
// shared by the cell chain and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 16;

  localparam int PRIO_W   = 4;
  localparam int AGE_W    = 8;
  localparam int GENDER_W = 2;
  localparam int TAG_W    = 16;
  localparam int OCC_W    = 5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Packed with the priority in the lowest bits, as on the stream data bus.
  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [GENDER_W-1:0] gender;
    logic [AGE_W-1:0]    age;
    logic [PRIO_W-1:0]   prio;
  } entry_t;

  // Broadcast to every cell of the chain in each cycle.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

FILE: src/spq_cell.sv
// ----------------------------------------------------------------------------
// Stable priority queue cell
// One slot of the sorted chain. It holds its entry, takes the new entry,
// its left neighbour's entry or its right neighbour's entry each cycle.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic              occupied,
  input  logic              left_stays,
  input  spq_pkg::entry_t   left_entry,
  input  spq_pkg::entry_t   right_entry,
  output spq_pkg::entry_t   entry,
  output logic              stays
);
  import spq_pkg::*;

  entry_t entry_next;

  // An occupied entry with equal or better priority stays ahead of the new one,
  // which is what keeps ties in arrival order.
  assign stays = occupied && (entry.prio <= ctl.new_entry.prio);

  always_comb begin
    entry_next = entry;
    if (ctl.enq) begin
      if (!stays) begin
        if (left_stays) begin
          entry_next = ctl.new_entry;
        end else begin
          entry_next = left_entry;
        end
      end
    end else if (ctl.deq) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

FILE: src/stable_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Stable priority queue unit
// Bounded priority queue built as a chain of sorted cells; lower priority
// numbers leave first and equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
//  Channel  Direction  tdata (low bit up)                         tuser
//  s_*      in         priority, age, gender, tag                 op
//  m_*      out        priority, age, gender, tag, occupancy      status
//
//  The whole cell chain inserts or shifts at once for every transaction, and
//  the result lands in the output register in the next cycle.
//  One input transaction is taken per cycle while the output register is free
//  or being drained; a stalled output holds s_tready low.
//  Synchronous reset empties the queue and holds s_tready low; entry contents
//  are not cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [3:0] priority, [11:4] age, [13:12] gender, [29:14] tag
  input  logic [0:0]  s_tuser,  // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // [3:0] priority, [11:4] age, [13:12] gender,
                                // [29:14] tag, [34:30] occupancy
  output logic [1:0]  m_tuser   // [1:0] status
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] entry_count_next;
  logic             accept;
  logic             is_full;
  logic             is_empty;
  entry_t           new_entry;
  cell_ctl_t        ctl;
  status_t          status_next;
  entry_t           out_entry_next;
  entry_t           out_entry;
  status_t          out_status;
  logic [CNT_W-1:0] out_count;

  entry_t           cell_entry [QUEUE_DEPTH];
  logic             cell_stays [QUEUE_DEPTH];

  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign is_full  = (entry_count == FULL_CNT);
  assign is_empty = (entry_count == '0);

  assign new_entry = s_tdata[$bits(entry_t)-1:0];

  always_comb begin
    ctl.new_entry    = new_entry;
    ctl.enq          = accept && (s_tuser[0] == OP_ENQ) && !is_full;
    ctl.deq          = accept && (s_tuser[0] == OP_DEQ) && !is_empty;
    entry_count_next = entry_count;
    status_next      = ST_OK;
    out_entry_next   = '0;
    if (s_tuser[0] == OP_ENQ) begin
      if (is_full) begin
        status_next = ST_FULL;
      end else begin
        entry_count_next = entry_count + CNT_W'(1);
      end
    end else begin
      if (is_empty) begin
        status_next = ST_EMPTY;
      end else begin
        entry_count_next = entry_count - CNT_W'(1);
        out_entry_next   = cell_entry[0];
      end
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   left_stays;
    entry_t left_entry;
    entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_stays = 1'b1;
      assign left_entry = new_entry;
    end else begin : g_body
      assign left_stays = cell_stays[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = new_entry;
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (CNT_W'(i) < entry_count),
      .left_stays  (left_stays),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .stays       (cell_stays[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (accept) begin
        entry_count <= entry_count_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_entry  <= out_entry_next;
      out_status <= status_next;
      out_count  <= entry_count_next;
    end
  end

  assign m_tdata = {5'b0, OCC_W'(out_count), out_entry};
  assign m_tuser = out_status;

endmodule

FILE: src/spq_checker.sv
// ----------------------------------------------------------------------------
// Stable priority queue checker
// Port-level assertions on the queue unit, attached by a bind statement.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import spq_pkg::*;

  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

  // The input side is held back only by a result that is waiting.
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not follow the output register");

  // Every accepted transaction gives a result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted transaction gave no result");

  // A dropped enqueue is reported only when every slot is taken.
  a_full_occupancy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_FULL)) |-> (m_tdata[34:30] == FULL_OCC))
    else $error("full status with occupancy below depth");

  // An empty dequeue reports no entry and an empty queue.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_EMPTY)) |-> (m_tdata == '0))
    else $error("empty status with non-zero result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind stable_priority_queue_unit spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (.*);
